[rtl/scalar_tensor_float_alu_unit_defines.svh]
// assertion macros for the scalar tensor float alu
`ifndef SCALAR_TENSOR_FLOAT_ALU_UNIT_DEFINES_SVH
`define SCALAR_TENSOR_FLOAT_ALU_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define STFALU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define STFALU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/stfalu_pkg.sv]
// shared types, codes and unpack helpers for the scalar tensor float alu
`default_nettype none

package stfalu_pkg;

  // operation codes
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_RSUB = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_RDIV = 3'd5;

  // configuration register indexes
  localparam logic CFG_OPERATION = 1'b0;
  localparam logic CFG_SCALAR    = 1'b1;

  localparam logic [31:0] QNAN = 32'h7FC00000;

  localparam int EXP_W   = 12;
  localparam int LAT_ADD = 3;
  localparam int LAT_MUL = 2;
  localparam int LAT_DIV = 28;
  localparam int NSTG    = LAT_DIV + 4;

  // unpacked operand, mantissa normalized with leading one at bit 23
  typedef struct packed {
    logic                    sign;
    logic signed [EXP_W-1:0] exp;
    logic [23:0]             mant;
    logic                    zero;
    logic                    inf;
    logic                    nan;
  } opnd_t;

  // unrounded result, leading one at bit 26, value mant/2^26 * 2^exp
  typedef struct packed {
    logic                    sign;
    logic signed [EXP_W-1:0] exp;
    logic [26:0]             mant;
    logic                    sticky;
  } unr_t;

  // result fixed ahead of the arithmetic
  typedef struct packed {
    logic        hit;
    logic [31:0] bits;
  } spec_t;

  // control that travels beside the arithmetic cores
  typedef struct packed {
    logic [2:0] op;
    logic       dz;
    logic       last;
    spec_t      spec;
  } side_t;

  function automatic opnd_t unpack(input logic [31:0] x);
    opnd_t      o;
    logic [23:0] m;
    logic [4:0]  lz;
    logic        found;
    m     = {x[30:23] != 8'd0, x[22:0]};
    lz    = '0;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found) begin
        if (m[i]) found = 1'b1;
        else lz = lz + 5'd1;
      end
    end
    o.sign = x[31];
    o.mant = m << lz;
    o.exp  = ((x[30:23] == 8'd0) ? -12'sd126 : ($signed({4'd0, x[30:23]}) - 12'sd127))
             - $signed({7'd0, lz});
    o.zero = (x[30:0] == 31'd0);
    o.inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    o.nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    return o;
  endfunction

  // nan, infinity, zero and unused-code outcomes
  function automatic spec_t special(input logic [2:0] op, input logic [31:0] ab,
                                    input logic [31:0] bb, input opnd_t a, input opnd_t b);
    spec_t s;
    logic  sx;
    sx     = a.sign ^ b.sign;
    s.hit  = 1'b0;
    s.bits = '0;
    case (op) inside
      OP_ADD, OP_SUB, OP_RSUB: begin
        s.hit = 1'b1;
        if (a.nan || b.nan) s.bits = QNAN;
        else if (a.inf && b.inf) s.bits = (a.sign != b.sign) ? QNAN : {a.sign, 8'hFF, 23'd0};
        else if (a.inf) s.bits = {a.sign, 8'hFF, 23'd0};
        else if (b.inf) s.bits = {b.sign, 8'hFF, 23'd0};
        else if (a.zero && b.zero) s.bits = {a.sign & b.sign, 31'd0};
        else if (a.zero) s.bits = bb;
        else if (b.zero) s.bits = ab;
        else s.hit = 1'b0;
      end
      OP_MUL: begin
        s.hit = 1'b1;
        if (a.nan || b.nan || (a.inf && b.zero) || (a.zero && b.inf)) s.bits = QNAN;
        else if (a.inf || b.inf) s.bits = {sx, 8'hFF, 23'd0};
        else if (a.zero || b.zero) s.bits = {sx, 31'd0};
        else s.hit = 1'b0;
      end
      OP_DIV, OP_RDIV: begin
        s.hit = 1'b1;
        if (a.nan || b.nan || (a.inf && b.inf) || (a.zero && b.zero)) s.bits = QNAN;
        else if (a.inf || b.zero) s.bits = {sx, 8'hFF, 23'd0};
        else if (a.zero || b.inf) s.bits = {sx, 31'd0};
        else s.hit = 1'b0;
      end
      default: begin
        s.hit  = 1'b1;
        s.bits = '0;
      end
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[rtl/stfalu_add.sv]
// three-stage float adder core: align, add, normalize
`default_nettype none

module stfalu_add (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire stfalu_pkg::opnd_t a,
  input  wire stfalu_pkg::opnd_t b,
  output stfalu_pkg::unr_t      res
);

  // stage 1 registers
  logic                                sign1;
  logic                                sub1;
  logic signed [stfalu_pkg::EXP_W-1:0] exp1;
  logic [26:0]                         bm1;
  logic [26:0]                         sm1;
  // stage 2 registers
  logic                                sign2;
  logic signed [stfalu_pkg::EXP_W-1:0] exp2;
  logic [27:0]                         sum2;

  stfalu_pkg::opnd_t                   big;
  stfalu_pkg::opnd_t                   sml;
  logic signed [stfalu_pkg::EXP_W-1:0] d;
  logic [26:0]                         s27;
  logic [26:0]                         shf;
  logic                                lost;
  logic [4:0]                          lz;
  logic                                found;
  logic [27:0]                         norm;

  // pick larger magnitude and align the smaller one with sticky
  always_comb begin
    if ((a.exp > b.exp) || ((a.exp == b.exp) && (a.mant >= b.mant))) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    d   = big.exp - sml.exp;
    s27 = {sml.mant, 3'b000};
    if (d >= 12'sd27) begin
      shf  = '0;
      lost = 1'b1;
    end else begin
      shf  = s27 >> d[4:0];
      lost = |(s27 & ((27'd1 << d[4:0]) - 27'd1));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sign1 <= big.sign;
      sub1  <= a.sign ^ b.sign;
      exp1  <= big.exp;
      bm1   <= {big.mant, 3'b000};
      sm1   <= {shf[26:1], shf[0] | lost};
    end
  end

  // magnitude add or subtract
  always_ff @(posedge clk) begin
    if (en) begin
      sign2 <= sign1;
      exp2  <= exp1;
      sum2  <= sub1 ? ({1'b0, bm1} - {1'b0, sm1}) : ({1'b0, bm1} + {1'b0, sm1});
    end
  end

  // leading-zero count and normalize
  always_comb begin
    lz    = '0;
    found = 1'b0;
    for (int i = 27; i >= 0; i--) begin
      if (!found) begin
        if (sum2[i]) found = 1'b1;
        else lz = lz + 5'd1;
      end
    end
    norm = sum2 << lz;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.sign   <= (sum2 == 28'd0) ? 1'b0 : sign2;
      res.exp    <= exp2 + 12'sd1 - $signed({7'd0, lz});
      res.mant   <= norm[27:1];
      res.sticky <= norm[0];
    end
  end

endmodule

`default_nettype wire

[rtl/stfalu_mul.sv]
// two-stage float multiplier core: product, normalize
`default_nettype none

module stfalu_mul (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire stfalu_pkg::opnd_t a,
  input  wire stfalu_pkg::opnd_t b,
  output stfalu_pkg::unr_t      res
);

  logic                                sign1;
  logic signed [stfalu_pkg::EXP_W-1:0] exp1;
  logic [47:0]                         prod1;

  // mantissa product
  always_ff @(posedge clk) begin
    if (en) begin
      sign1 <= a.sign ^ b.sign;
      exp1  <= a.exp + b.exp;
      prod1 <= a.mant * b.mant;
    end
  end

  // one-bit normalize
  always_ff @(posedge clk) begin
    if (en) begin
      res.sign <= sign1;
      if (prod1[47]) begin
        res.exp    <= exp1 + 12'sd1;
        res.mant   <= prod1[47:21];
        res.sticky <= |prod1[20:0];
      end else begin
        res.exp    <= exp1;
        res.mant   <= prod1[46:20];
        res.sticky <= |prod1[19:0];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/stfalu_div.sv]
// pipelined restoring divider core, one quotient bit per stage
`default_nettype none

module stfalu_div (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire stfalu_pkg::opnd_t a,
  input  wire stfalu_pkg::opnd_t b,
  output stfalu_pkg::unr_t      res
);

  localparam int NQ = stfalu_pkg::LAT_DIV - 1;

  typedef struct packed {
    logic                                sign;
    logic signed [stfalu_pkg::EXP_W-1:0] exp;
    logic [23:0]                         dvs;
    logic [24:0]                         rem;
    logic [26:0]                         q;
  } dstg_t;

  dstg_t st [stfalu_pkg::LAT_DIV];
  logic  lt;

  // prescale so the quotient lies in [1,2)
  assign lt = (a.mant < b.mant);

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].sign <= a.sign ^ b.sign;
      st[0].exp  <= a.exp - b.exp - $signed({11'd0, lt});
      st[0].dvs  <= b.mant;
      st[0].rem  <= lt ? {a.mant, 1'b0} : {1'b0, a.mant};
      st[0].q    <= '0;
    end
  end

  // quotient bit stages
  for (genvar k = 1; k <= NQ; k++) begin : g_step
    logic        ge;
    logic [24:0] diff;
    assign ge   = (st[k-1].rem >= {1'b0, st[k-1].dvs});
    assign diff = ge ? (st[k-1].rem - {1'b0, st[k-1].dvs}) : st[k-1].rem;
    always_ff @(posedge clk) begin
      if (en) begin
        st[k].sign <= st[k-1].sign;
        st[k].exp  <= st[k-1].exp;
        st[k].dvs  <= st[k-1].dvs;
        st[k].rem  <= {diff[23:0], 1'b0};
        st[k].q    <= {st[k-1].q[25:0], ge};
      end
    end
  end

  assign res.sign   = st[NQ].sign;
  assign res.exp    = st[NQ].exp;
  assign res.mant   = st[NQ].q;
  assign res.sticky = (st[NQ].rem != 25'd0);

endmodule

`default_nettype wire

[rtl/stfalu_round.sv]
// two-stage round-to-nearest-even and pack, with special override
`default_nettype none

module stfalu_round (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire stfalu_pkg::unr_t  u,
  input  wire stfalu_pkg::side_t side,
  output logic [31:0]            result_bits,
  output logic                   divided_by_zero,
  output logic                   last_out
);

  typedef struct packed {
    logic        sign;
    logic [30:0] body;
    logic        g;
    logic        st;
    logic        ovf;
    logic        zero;
  } rnd_t;

  rnd_t                                r1;
  stfalu_pkg::side_t                   side1;
  logic signed [stfalu_pkg::EXP_W-1:0] be;
  logic signed [stfalu_pkg::EXP_W-1:0] k;
  logic [26:0]                         sh;
  logic                                lost;
  rnd_t                                r1_next;
  logic                                inc;
  logic [30:0]                         packed_body;

  // biased exponent, denormal shift and guard/sticky
  always_comb begin
    be   = u.exp + 12'sd127;
    k    = 12'sd1 - be;
    sh   = '0;
    lost = 1'b0;
    r1_next.sign = u.sign;
    r1_next.zero = ~u.mant[26];
    r1_next.ovf  = (be >= 12'sd255);
    if (be >= 12'sd1) begin
      r1_next.body = {be[7:0], u.mant[25:3]};
      r1_next.g    = u.mant[2];
      r1_next.st   = u.mant[1] | u.mant[0] | u.sticky;
    end else begin
      if (k >= 12'sd27) begin
        sh   = '0;
        lost = |u.mant;
      end else begin
        sh   = u.mant >> k[4:0];
        lost = |(u.mant & ((27'd1 << k[4:0]) - 27'd1));
      end
      r1_next.body = {8'd0, sh[25:3]};
      r1_next.g    = sh[2];
      r1_next.st   = sh[1] | sh[0] | lost | u.sticky;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1    <= r1_next;
      side1 <= side;
    end
  end

  // round increment; a carry walks into the exponent field
  always_comb begin
    inc         = r1.g & (r1.st | r1.body[0]);
    packed_body = r1.body + {30'd0, inc};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      divided_by_zero <= side1.dz;
      last_out        <= side1.last;
      if (side1.spec.hit) result_bits <= side1.spec.bits;
      else if (r1.zero) result_bits <= {r1.sign, 31'd0};
      else if (r1.ovf) result_bits <= {r1.sign, 8'hFF, 23'd0};
      else result_bits <= {r1.sign, packed_body};
    end
  end

endmodule

`default_nettype wire

[rtl/scalar_tensor_float_alu_unit.sv]
// top level: elementwise float32 scalar alu pipeline
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data       | in
//  in      | in_valid in_stall element_bits last_in       | in
//  out     | out_valid out_stall result_bits              | out
//          | divided_by_zero last_out                     |
//
// one request per cycle enters while in_stall is low; the pipeline depth is set by
// the 27 quotient-bit stages of the divider plus select, prescale, unpack and round.
// add and multiply results are delayed to match the divider path.
// rst clears valid bits and the configuration registers.
// out_stall with a waiting result freezes the whole pipeline, and in_stall follows.
`default_nettype none

module scalar_tensor_float_alu_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] element_bits,
  input  wire logic        last_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      result_bits,
  output logic             divided_by_zero,
  output logic             last_out
);

`include "scalar_tensor_float_alu_unit_defines.svh"

  localparam int NSTG  = stfalu_pkg::NSTG;
  localparam int LDIV  = stfalu_pkg::LAT_DIV;
  localparam int DADD  = stfalu_pkg::LAT_DIV - stfalu_pkg::LAT_ADD;
  localparam int DMUL  = stfalu_pkg::LAT_DIV - stfalu_pkg::LAT_MUL;

  logic [2:0]         operation;
  logic [31:0]        scalar_bits;
  logic               en;
  logic [NSTG-1:0]    vld;

  logic [2:0]         op_sel;
  logic [31:0]        a_sel;
  logic [31:0]        b_sel;
  logic               dz_sel;

  logic [2:0]         s1_op;
  logic [31:0]        s1_a;
  logic [31:0]        s1_b;
  logic               s1_dz;
  logic               s1_last;

  stfalu_pkg::opnd_t  ua;
  stfalu_pkg::opnd_t  ub;
  stfalu_pkg::opnd_t  s2_a;
  stfalu_pkg::opnd_t  s2_b;
  stfalu_pkg::side_t  s2_side;

  stfalu_pkg::unr_t   add_res;
  stfalu_pkg::unr_t   mul_res;
  stfalu_pkg::unr_t   div_res;
  stfalu_pkg::unr_t   add_q  [DADD];
  stfalu_pkg::unr_t   mul_q  [DMUL];
  stfalu_pkg::side_t  side_q [LDIV];
  stfalu_pkg::unr_t   core_res;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      operation   <= stfalu_pkg::OP_ADD;
      scalar_bits <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        stfalu_pkg::CFG_OPERATION: operation   <= cfg_data[2:0];
        stfalu_pkg::CFG_SCALAR:    scalar_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance and valid bits
  assign en        = ~(vld[NSTG-1] & out_stall);
  assign in_stall  = ~en;
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  // operand order, sign flip and divide-by-zero flag
  always_comb begin
    op_sel = operation;
    a_sel  = element_bits;
    b_sel  = scalar_bits;
    case (operation)
      stfalu_pkg::OP_SUB:  b_sel = {~scalar_bits[31], scalar_bits[30:0]};
      stfalu_pkg::OP_RSUB: begin
        a_sel = scalar_bits;
        b_sel = {~element_bits[31], element_bits[30:0]};
      end
      stfalu_pkg::OP_RDIV: begin
        a_sel = scalar_bits;
        b_sel = element_bits;
      end
      default: ;
    endcase
    dz_sel = ((operation == stfalu_pkg::OP_DIV) && (scalar_bits[30:0] == 31'd0)) ||
             ((operation == stfalu_pkg::OP_RDIV) && (element_bits[30:0] == 31'd0));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op   <= op_sel;
      s1_a    <= a_sel;
      s1_b    <= b_sel;
      s1_dz   <= dz_sel;
      s1_last <= last_in;
    end
  end

  // unpack and special-case detection
  assign ua = stfalu_pkg::unpack(s1_a);
  assign ub = stfalu_pkg::unpack(s1_b);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_a         <= ua;
      s2_b         <= ub;
      s2_side.op   <= s1_op;
      s2_side.dz   <= s1_dz;
      s2_side.last <= s1_last;
      s2_side.spec <= stfalu_pkg::special(s1_op, s1_a, s1_b, ua, ub);
    end
  end

  // arithmetic cores
  stfalu_add u_add (.clk(clk), .en(en), .a(s2_a), .b(s2_b), .res(add_res));
  stfalu_mul u_mul (.clk(clk), .en(en), .a(s2_a), .b(s2_b), .res(mul_res));
  stfalu_div u_div (.clk(clk), .en(en), .a(s2_a), .b(s2_b), .res(div_res));

  // latency matching for add, multiply and control
  always_ff @(posedge clk) begin
    if (en) begin
      add_q[0]  <= add_res;
      mul_q[0]  <= mul_res;
      side_q[0] <= s2_side;
      for (int i = 1; i < DADD; i++) add_q[i] <= add_q[i-1];
      for (int i = 1; i < DMUL; i++) mul_q[i] <= mul_q[i-1];
      for (int i = 1; i < LDIV; i++) side_q[i] <= side_q[i-1];
    end
  end

  // core result select
  always_comb begin
    case (side_q[LDIV-1].op) inside
      stfalu_pkg::OP_ADD, stfalu_pkg::OP_SUB, stfalu_pkg::OP_RSUB: core_res = add_q[DADD-1];
      stfalu_pkg::OP_MUL: core_res = mul_q[DMUL-1];
      default:            core_res = div_res;
    endcase
  end

  stfalu_round u_round (
    .clk             (clk),
    .en              (en),
    .u               (core_res),
    .side            (side_q[LDIV-1]),
    .result_bits     (result_bits),
    .divided_by_zero (divided_by_zero),
    .last_out        (last_out)
  );

  // checks
  `STFALU_ASSERT_NOW(a_dz_gives_inf_or_nan, out_valid && divided_by_zero,
    result_bits[30:23] == 8'hFF, "divide-by-zero result is not inf or nan")
  `STFALU_ASSERT_NOW(a_nan_canonical,
    out_valid && (result_bits[30:23] == 8'hFF) && (result_bits[22:0] != 23'd0),
    result_bits == stfalu_pkg::QNAN, "nan result is not canonical")
  `STFALU_ASSERT_NEXT(a_stall_freezes_pipe, out_valid && out_stall,
    $stable(vld), "pipeline moved while output stalled")

endmodule

`default_nettype wire
